>>> hdl/lpr_pkg.sv
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared types, codes and helpers for the IPv4 longest-prefix router.
// ----------------------------------------------------------------------------
package lpr_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int NUM_PORTS_DEF   = 64;
    localparam int SLOT_W          = 10;
    localparam int ADDR_W          = 32;
    localparam int LEN_W           = 6;
    localparam int PORT_W          = 6;
    localparam int TTL_W           = 8;
    localparam logic [LEN_W-1:0]  MAX_LEN        = 6'd32;
    localparam logic [ADDR_W-1:0] FALLBACK_RESET = 32'hAB434C01;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_ROUTE = 1'b1;

    localparam logic [1:0] ST_STORED = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_FWD    = 2'd2;
    localparam logic [1:0] ST_DROP   = 2'd3;

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] prefix;
        logic [LEN_W-1:0]  len;
        logic              has_gw;
        logic [ADDR_W-1:0] gw;
        logic [PORT_W-1:0] port;
        logic [ADDR_W-1:0] dst;
        logic [TTL_W-1:0]  ttl;
    } query_t;

    typedef struct packed {
        logic              valid;
        logic              hit;
        logic [SLOT_W-1:0] hit_slot;
        logic              free;
        logic [SLOT_W-1:0] free_slot;
        logic              found;
        logic [LEN_W-1:0]  best_len;
        logic [ADDR_W-1:0] best_prefix;
        logic [PORT_W-1:0] port;
        logic [ADDR_W-1:0] hop;
    } acc_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] prefix;
        logic [LEN_W-1:0]  len;
        logic              has_gw;
        logic [ADDR_W-1:0] gw;
        logic [PORT_W-1:0] port;
    } wr_t;

    function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
        logic [ADDR_W-1:0] m;
        if (len == '0) begin
            m = '0;
        end else begin
            m = {ADDR_W{1'b1}} << (MAX_LEN - len);
        end
        return m;
    endfunction

endpackage

>>> hdl/lpr_cell.sv
// ----------------------------------------------------------------------------
// lpr_cell
// One route table entry; updates the passing search item and hands it on.
// ----------------------------------------------------------------------------
module lpr_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  lpr_pkg::query_t q,
    input  lpr_pkg::wr_t    wr,
    input  lpr_pkg::acc_t   acc_in,
    output lpr_pkg::acc_t   acc_out
);

    logic                               valid_reg;
    logic [lpr_pkg::ADDR_W-1:0]         prefix_reg;
    logic [lpr_pkg::LEN_W-1:0]          len_reg;
    logic                               has_gw_reg;
    logic [lpr_pkg::ADDR_W-1:0]         gw_reg;
    logic [lpr_pkg::PORT_W-1:0]         port_reg;
    lpr_pkg::acc_t                      acc_reg;
    lpr_pkg::acc_t                      acc_next;
    logic [lpr_pkg::ADDR_W-1:0]         mask;
    logic                               wr_hit;
    logic                               match;
    logic                               better;

    localparam logic [lpr_pkg::SLOT_W-1:0] MY_SLOT = CELL_INDEX[lpr_pkg::SLOT_W-1:0];

    assign wr_hit = wr.en && (wr.slot == MY_SLOT);
    assign mask   = lpr_pkg::len_mask(len_reg);
    assign match  = valid_reg && ((prefix_reg & mask) == (q.dst & mask));
    assign better = !acc_in.found || (len_reg > acc_in.best_len) ||
                    ((len_reg == acc_in.best_len) && (prefix_reg < acc_in.best_prefix));

    always_comb begin
        acc_next = acc_in;
        if (q.op == lpr_pkg::OP_ADD) begin
            if (valid_reg && !acc_in.hit && (prefix_reg == q.prefix)) begin
                acc_next.hit      = 1'b1;
                acc_next.hit_slot = MY_SLOT;
            end
            if (!valid_reg && !acc_in.free) begin
                acc_next.free      = 1'b1;
                acc_next.free_slot = MY_SLOT;
            end
        end else if (match && better) begin
            acc_next.found       = 1'b1;
            acc_next.best_len    = len_reg;
            acc_next.best_prefix = prefix_reg;
            acc_next.port        = port_reg;
            acc_next.hop         = has_gw_reg ? gw_reg : q.dst;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            acc_reg   <= '0;
        end else begin
            if (wr_hit) begin
                valid_reg <= 1'b1;
            end
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_hit) begin
            prefix_reg <= wr.prefix;
            len_reg    <= wr.len;
            has_gw_reg <= wr.has_gw;
            gw_reg     <= wr.gw;
            port_reg   <= wr.port;
        end
    end

    assign acc_out = acc_reg;

endmodule

>>> hdl/ipv4_longest_prefix_router.sv
// ----------------------------------------------------------------------------
// ipv4_longest_prefix_router
// IPv4 routing table with route add and longest-prefix-match lookup.
// ----------------------------------------------------------------------------
// Input channel s_*: tuser is the operation (0 add route, 1 route datagram),
// tdata carries the route and datagram fields. Output channel m_*: tuser is
// the status (stored, table full, forwarded, dropped for TTL), tdata the
// chosen port, next hop and decremented TTL. cfg_we/cfg_wdata set the
// fallback next hop used when no entry matches.
// Each table entry lives in one cell of a chain; an accepted item walks the
// chain one cell per cycle, and one item is worked on at a time: with a
// ready receiver a new item is accepted as soon as the previous result has
// moved into the output register.
// Reset empties the table and restores the fallback hop; no clearing pass.
// A stalled receiver holds the result in place; the next result waits in a
// holding register until the output register frees up.
// ----------------------------------------------------------------------------
module ipv4_longest_prefix_router #(
    parameter int TABLE_DEPTH = lpr_pkg::TABLE_DEPTH_DEF,
    parameter int NUM_PORTS   = lpr_pkg::NUM_PORTS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // route_prefix_value, route_length, gateway_present, gateway_addr,
    // route_port, dest_addr, hop_limit, zero fill
    input  logic [119:0] s_tdata,
    // operation
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_port, out_next_hop, out_hop_limit, zero fill
    output logic [47:0]  m_tdata,
    // status
    output logic [1:0]   m_tuser,
    input  logic         cfg_we,
    input  logic [31:0]  cfg_wdata
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_PEND = 3'b100
    } state_t;

    state_t                         state_reg, state_next;
    lpr_pkg::query_t                q_reg;
    lpr_pkg::query_t                q_next;
    logic                           go_reg;
    logic [31:0]                    fallback_reg;
    lpr_pkg::acc_t                  chain [TABLE_DEPTH+1];
    lpr_pkg::acc_t                  tail;
    lpr_pkg::wr_t                   wr;
    logic [1:0]                     res_status_reg, res_status_next;
    logic [5:0]                     res_port_reg, res_port_next;
    logic [31:0]                    res_hop_reg, res_hop_next;
    logic [7:0]                     res_ttl_reg, res_ttl_next;
    logic                           m_tvalid_reg;
    logic [47:0]                    m_tdata_reg;
    logic [1:0]                     m_tuser_reg;
    logic                           accept;
    logic                           load_out;
    logic [5:0]                     in_len;
    logic [5:0]                     port_mod;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign load_out = (state_reg == S_PEND) && (!m_tvalid_reg || m_tready);

    assign in_len   = s_tdata[37:32];

    // port reduction as a constant lookup over all input port values
    always_comb begin
        port_mod = '0;
        for (int v = 0; v < 2 ** lpr_pkg::PORT_W; v++) begin
            if (s_tdata[76:71] == 6'(v)) begin
                port_mod = 6'(v % NUM_PORTS);
            end
        end
    end

    always_comb begin
        q_next.op     = s_tuser;
        q_next.prefix = s_tdata[31:0];
        q_next.len    = (in_len > lpr_pkg::MAX_LEN) ? lpr_pkg::MAX_LEN : in_len;
        q_next.has_gw = s_tdata[38];
        q_next.gw     = s_tdata[38] ? s_tdata[70:39] : 32'd0;
        q_next.port   = port_mod;
        q_next.dst    = s_tdata[108:77];
        q_next.ttl    = s_tdata[116:109];
    end

    always_comb begin
        chain[0]       = '0;
        chain[0].valid = go_reg;
    end

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        lpr_cell #(
            .CELL_INDEX(i)
        ) u_cell (
            .aclk   (aclk),
            .aresetn(aresetn),
            .q      (q_reg),
            .wr     (wr),
            .acc_in (chain[i]),
            .acc_out(chain[i+1])
        );
    end

    assign tail = chain[TABLE_DEPTH];

    always_comb begin
        wr.en     = 1'b0;
        wr.slot   = tail.hit ? tail.hit_slot : tail.free_slot;
        wr.prefix = q_reg.prefix;
        wr.len    = q_reg.len;
        wr.has_gw = q_reg.has_gw;
        wr.gw     = q_reg.gw;
        wr.port   = q_reg.port;
        res_status_next = res_status_reg;
        res_port_next   = res_port_reg;
        res_hop_next    = res_hop_reg;
        res_ttl_next    = res_ttl_reg;
        if (tail.valid) begin
            res_port_next = '0;
            res_hop_next  = '0;
            res_ttl_next  = '0;
            if (q_reg.op == lpr_pkg::OP_ADD) begin
                if (tail.hit || tail.free) begin
                    wr.en           = 1'b1;
                    res_status_next = lpr_pkg::ST_STORED;
                end else begin
                    res_status_next = lpr_pkg::ST_FULL;
                end
            end else if (q_reg.ttl <= 8'd1) begin
                res_status_next = lpr_pkg::ST_DROP;
            end else begin
                res_status_next = lpr_pkg::ST_FWD;
                res_port_next   = tail.found ? tail.port : 6'd0;
                res_hop_next    = tail.found ? tail.hop : fallback_reg;
                res_ttl_next    = q_reg.ttl - 8'd1;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_WALK;
                end
            end
            S_WALK: begin
                if (tail.valid) begin
                    state_next = S_PEND;
                end
            end
            S_PEND: begin
                if (load_out) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            go_reg       <= 1'b0;
            fallback_reg <= lpr_pkg::FALLBACK_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            go_reg    <= accept;
            if (cfg_we) begin
                fallback_reg <= cfg_wdata;
            end
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            q_reg <= q_next;
        end
        res_status_reg <= res_status_next;
        res_port_reg   <= res_port_next;
        res_hop_reg    <= res_hop_next;
        res_ttl_reg    <= res_ttl_next;
        if (load_out) begin
            m_tdata_reg <= {2'b00, res_ttl_reg, res_hop_reg, res_port_reg};
            m_tuser_reg <= res_status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
